### hw/rtl/nonpreemptive_priority_scheduler_defines.svh
// assertion macros for the priority scheduler
`ifndef NONPREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH
`define NONPREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define NPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");
`define NPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");
`else
`define NPS_ASSERT_NOW(lbl, ante, cons)
`define NPS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### hw/rtl/nps_pkg.sv
// constants, control word type and microprogram of the priority scheduler
package nps_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int ARR_W     = 16;
  localparam int BUR_W     = 16;
  localparam int PRI_W     = 8;
  localparam int TIME_W    = 21;
  localparam int PID_W     = 4;
  localparam int REC_W     = ARR_W + BUR_W + PRI_W;
  localparam int PC_W      = 4;

  // wait selects
  localparam logic [1:0] W_NONE = 2'd0;
  localparam logic [1:0] W_IN   = 2'd1;
  localparam logic [1:0] W_OUT  = 2'd2;

  // jump conditions
  localparam logic [2:0] C_NEXT     = 3'd0;
  localparam logic [2:0] C_ALWAYS   = 3'd1;
  localparam logic [2:0] C_NOTLAST  = 3'd2;
  localparam logic [2:0] C_ROUNDEND = 3'd3;
  localparam logic [2:0] C_KMID     = 3'd4;

  // program steps
  localparam logic [PC_W-1:0] S_LOAD  = 4'd0;
  localparam logic [PC_W-1:0] S_RINIT = 4'd1;
  localparam logic [PC_W-1:0] S_RD    = 4'd2;
  localparam logic [PC_W-1:0] S_CMP   = 4'd3;
  localparam logic [PC_W-1:0] S_PICK  = 4'd4;
  localparam logic [PC_W-1:0] S_OINIT = 4'd5;
  localparam logic [PC_W-1:0] S_ORD   = 4'd6;
  localparam logic [PC_W-1:0] S_OCALC = 4'd7;
  localparam logic [PC_W-1:0] S_DONE  = 4'd8;

  typedef struct packed {
    logic            load;
    logic            scan_init;
    logic            cmp;
    logic            pick;
    logic            oinit;
    logic            oload;
    logic            clr;
    logic [1:0]      wait_sel;
    logic [2:0]      cond;
    logic [PC_W-1:0] jmp;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '0;
    case (pc)
      S_LOAD: begin
        w.load = 1'b1; w.wait_sel = W_IN; w.cond = C_NOTLAST; w.jmp = S_LOAD;
      end
      S_RINIT: begin
        w.scan_init = 1'b1; w.cond = C_ROUNDEND; w.jmp = S_OINIT;
      end
      S_RD: begin
        w.cond = C_NEXT;
      end
      S_CMP: begin
        w.cmp = 1'b1; w.cond = C_KMID; w.jmp = S_RD;
      end
      S_PICK: begin
        w.pick = 1'b1; w.cond = C_ALWAYS; w.jmp = S_RINIT;
      end
      S_OINIT: begin
        w.oinit = 1'b1; w.cond = C_NEXT;
      end
      S_ORD: begin
        w.cond = C_NEXT;
      end
      S_OCALC: begin
        w.oload = 1'b1; w.wait_sel = W_OUT; w.cond = C_KMID; w.jmp = S_ORD;
      end
      S_DONE: begin
        w.clr = 1'b1; w.cond = C_ALWAYS; w.jmp = S_LOAD;
      end
      default: begin
        w.cond = C_ALWAYS; w.jmp = S_LOAD;
      end
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/nps_ram.sv
// generic single write port ram with registered read
module nps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/nonpreemptive_priority_scheduler.sv
// non-preemptive priority scheduler, microcoded sequencer top level
//
// input channel (in_valid/in_ready): one process record per transfer,
// arrival, burst and prio; last marks the final record and starts a run.
// records past the sixteenth are dropped, a last one still starts the run.
// loading takes one record per cycle while in_ready and in_valid are high.
// after the last record the sequencer schedules: each round scans all n
// records through the record ram, a read step and a compare step each,
// then a pick step marks the chosen process done and advances the clock.
// output channel (out_valid/out_ready): one result per loaded process in
// load order, proc_id, completion, turnaround, waiting; final_res marks the
// last one. results follow one another while the receiver takes them.
// a stalled receiver holds the output register and the sequencer waits.
// the final result may still wait while the next run starts loading.
// rst (synchronous, active high) clears the sequencer, counts and marks.
`include "nonpreemptive_priority_scheduler_defines.svh"

module nonpreemptive_priority_scheduler
  import nps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ARR_W-1:0]  arrival,
  input  logic [BUR_W-1:0]  burst,
  input  logic [PRI_W-1:0]  prio,
  input  logic              last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PID_W-1:0]  proc_id,
  output logic [TIME_W-1:0] completion,
  output logic [TIME_W-1:0] turnaround,
  output logic [TIME_W-1:0] waiting,
  output logic              final_res
);

  logic [PC_W-1:0]      pc, pc_next;
  ucode_t               ctl;
  logic                 proceed, cond_true, out_free;

  logic [CNT_W-1:0]     loaded_count, round;
  logic [IDX_W-1:0]     k;
  logic [TIME_W-1:0]    clock_now;
  logic [MAX_PROCS-1:0] done_marks;
  logic                 have_ready, have_any;
  logic [IDX_W-1:0]     rdy_idx, ear_idx;
  logic [PRI_W-1:0]     rdy_pri, ear_pri;
  logic [BUR_W-1:0]     rdy_bur, ear_bur;
  logic [ARR_W-1:0]     ear_arr;

  logic [REC_W-1:0]     rec_rdata;
  logic [TIME_W-1:0]    fin_rdata;
  logic [ARR_W-1:0]     e_arr;
  logic [BUR_W-1:0]     e_bur;
  logic [PRI_W-1:0]     e_pri;
  logic                 klast, ent_ok, rdy_hit, ear_hit;
  logic                 rec_we, fin_we;
  logic [IDX_W-1:0]     sel_idx;
  logic [TIME_W-1:0]    finish_t, tat, wt;

  assign ctl      = ucode_rom(pc);
  assign in_ready = (ctl.wait_sel == W_IN);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    case (ctl.wait_sel)
      W_IN:    proceed = in_valid;
      W_OUT:   proceed = out_free;
      default: proceed = 1'b1;
    endcase
  end

  assign klast = ((CNT_W'(k) + CNT_W'(1)) == loaded_count);

  always_comb begin
    case (ctl.cond)
      C_ALWAYS:   cond_true = 1'b1;
      C_NOTLAST:  cond_true = !last;
      C_ROUNDEND: cond_true = (round == loaded_count);
      C_KMID:     cond_true = !klast;
      default:    cond_true = 1'b0;
    endcase
  end

  always_comb begin
    if (!proceed) begin
      pc_next = pc;
    end else if (cond_true) begin
      pc_next = ctl.jmp;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  // record and finish stores
  assign rec_we = ctl.load && proceed && (loaded_count < CNT_W'(MAX_PROCS));
  assign fin_we = ctl.pick;

  nps_ram #(.WIDTH(REC_W), .DEPTH(MAX_PROCS)) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (loaded_count[IDX_W-1:0]),
    .wdata ({arrival, burst, prio}),
    .raddr (k),
    .rdata (rec_rdata)
  );

  nps_ram #(.WIDTH(TIME_W), .DEPTH(MAX_PROCS)) u_fin_ram (
    .clk   (clk),
    .we    (fin_we),
    .waddr (sel_idx),
    .wdata (finish_t),
    .raddr (k),
    .rdata (fin_rdata)
  );

  assign e_arr = rec_rdata[REC_W-1 -: ARR_W];
  assign e_bur = rec_rdata[PRI_W +: BUR_W];
  assign e_pri = rec_rdata[PRI_W-1:0];

  // candidate compare
  assign ent_ok  = !done_marks[k];
  assign rdy_hit = ent_ok && ((TIME_W'(e_arr)) <= clock_now) &&
                   (!have_ready || (e_pri < rdy_pri));
  assign ear_hit = ent_ok && (!have_any || (e_arr < ear_arr) ||
                   ((e_arr == ear_arr) && (e_pri < ear_pri)));

  assign sel_idx  = have_ready ? rdy_idx : ear_idx;
  assign finish_t = have_ready ? (clock_now + TIME_W'(rdy_bur))
                               : (TIME_W'(ear_arr) + TIME_W'(ear_bur));

  assign tat = fin_rdata - TIME_W'(e_arr);
  assign wt  = tat - TIME_W'(e_bur);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= S_LOAD;
      loaded_count <= '0;
      round        <= '0;
      k            <= '0;
      clock_now    <= '0;
      done_marks   <= '0;
      have_ready   <= 1'b0;
      have_any     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      pc <= pc_next;
      if (rec_we) begin
        loaded_count <= loaded_count + CNT_W'(1);
      end
      if (ctl.scan_init) begin
        k          <= '0;
        have_ready <= 1'b0;
        have_any   <= 1'b0;
      end
      if (ctl.cmp) begin
        if (rdy_hit) begin
          have_ready <= 1'b1;
          rdy_idx    <= k;
          rdy_pri    <= e_pri;
          rdy_bur    <= e_bur;
        end
        if (ear_hit) begin
          have_any <= 1'b1;
          ear_idx  <= k;
          ear_arr  <= e_arr;
          ear_pri  <= e_pri;
          ear_bur  <= e_bur;
        end
        if (!klast) begin
          k <= k + IDX_W'(1);
        end
      end
      if (ctl.pick) begin
        clock_now           <= finish_t;
        done_marks[sel_idx] <= 1'b1;
        round               <= round + CNT_W'(1);
      end
      if (ctl.oinit) begin
        k <= '0;
      end
      if (ctl.oload && proceed) begin
        out_valid  <= 1'b1;
        proc_id    <= PID_W'(k);
        completion <= fin_rdata;
        turnaround <= tat;
        waiting    <= wt;
        final_res  <= klast;
        if (!klast) begin
          k <= k + IDX_W'(1);
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.clr) begin
        loaded_count <= '0;
        round        <= '0;
        k            <= '0;
        clock_now    <= '0;
        done_marks   <= '0;
      end
    end
  end

  `NPS_ASSERT_NOW(a_count_max, 1'b1, loaded_count <= CNT_W'(MAX_PROCS))
  `NPS_ASSERT_NOW(a_round_max, 1'b1, round <= loaded_count)
  `NPS_ASSERT_NOW(a_pick_pending, pc == S_PICK, have_any)
  `NPS_ASSERT_NEXT(a_run_cleared, pc == S_DONE, (loaded_count == '0) && (done_marks == '0))

endmodule
